/* hdl/qes_pkg.sv */
`timescale 1ns / 1ps
package qes_pkg;

    localparam int TOL_W = 16;

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_INF  = 2'd3
    } t_count;

    typedef struct packed {
        logic   vld;
        t_count kind;
    } t_ctl;

endpackage

/* hdl/qes_sqrt.sv */
`timescale 1ns / 1ps
module qes_sqrt #(
    parameter int SQW = 33
) (
    input  logic             i_clk,
    input  logic [2*SQW-1:0] i_rad,
    output logic [SQW-1:0]   o_root
);
    localparam int DW = 2 * SQW;
    localparam int RW = SQW + 3;

    logic [RW-1:0]  r_rem  [SQW];
    logic [SQW-1:0] r_root [SQW];
    logic [DW-1:0]  r_rad  [SQW];

    genvar k;
    for (k = 0; k < SQW; k++) begin : g_stage
        logic [RW-1:0]  rem_in;
        logic [SQW-1:0] root_in;
        logic [DW-1:0]  rad_in;
        logic [RW-1:0]  t;
        logic [RW-1:0]  trial;
        logic [RW-1:0]  n_rem;
        logic [SQW-1:0] n_root;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        always_comb begin
            t     = {rem_in[RW-3:0], rad_in[DW-1 -: 2]};
            trial = RW'({root_in, 2'b01});
            if (t >= trial) begin
                n_rem  = t - trial;
                n_root = {root_in[SQW-2:0], 1'b1};
            end else begin
                n_rem  = t;
                n_root = {root_in[SQW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_rad[k]  <= {rad_in[DW-3:0], 2'b00};
        end
    end

    assign o_root = r_root[SQW-1];

endmodule

/* hdl/qes_div.sv */
`timescale 1ns / 1ps
module qes_div #(
    parameter int NW   = 49,
    parameter int DENW = 33,
    parameter int WB   = 32
) (
    input  logic            i_clk,
    input  logic [NW-1:0]   i_mag,
    input  logic            i_neg,
    input  logic [DENW-1:0] i_den,
    output logic [WB-1:0]   o_root,
    output logic            o_ovf
);
    logic [DENW-1:0] r_rem [NW];
    logic [NW-1:0]   r_quo [NW];
    logic [NW-1:0]   r_dvd [NW];
    logic [DENW-1:0] r_den [NW];
    logic            r_neg [NW];
    logic [WB-1:0]   r_root;
    logic            r_ovf;

    genvar k;
    for (k = 0; k < NW; k++) begin : g_stage
        logic [DENW-1:0] rem_in;
        logic [NW-1:0]   quo_in;
        logic [NW-1:0]   dvd_in;
        logic [DENW-1:0] den_in;
        logic            neg_in;
        logic [DENW:0]   t;
        logic [DENW-1:0] n_rem;
        logic            qb;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign dvd_in = i_mag;
            assign den_in = i_den;
            assign neg_in = i_neg;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign dvd_in = r_dvd[k-1];
            assign den_in = r_den[k-1];
            assign neg_in = r_neg[k-1];
        end

        always_comb begin
            t = {rem_in, dvd_in[NW-1]};
            if (t >= {1'b0, den_in}) begin
                n_rem = DENW'(t - {1'b0, den_in});
                qb    = 1'b1;
            end else begin
                n_rem = DENW'(t);
                qb    = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_quo[k] <= {quo_in[NW-2:0], qb};
            r_dvd[k] <= {dvd_in[NW-2:0], 1'b0};
            r_den[k] <= den_in;
            r_neg[k] <= neg_in;
        end
    end

    logic [NW-1:0] q;
    logic [NW-1:0] half;
    logic [NW-1:0] lim;
    logic [NW-1:0] m;
    logic          neg_eff;
    logic          ovf;

    always_comb begin
        q       = r_quo[NW-1];
        half    = NW'(1) << (WB - 1);
        neg_eff = r_neg[NW-1] && (q != '0);
        lim     = neg_eff ? half : half - NW'(1);
        if (q > lim) begin
            m   = lim;
            ovf = 1'b1;
        end else begin
            m   = q;
            ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= neg_eff ? WB'(-m) : WB'(m);
        r_ovf  <= ovf;
    end

    assign o_root = r_root;
    assign o_ovf  = r_ovf;

endmodule

/* hdl/quadratic_equation_solver_unit.sv */
// Throughput: one transaction per cycle; busy stays low, every stage advances each cycle.
// Latency is set by the bit-per-stage square root and the two bit-per-stage dividers.
// Reset (synchronous, active low) clears the pipeline valid bits and the tolerance register r_tol.
// The receiver cannot stall: each result is shown on o_valid for one cycle.
`timescale 1ns / 1ps
module quadratic_equation_solver_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] i_coeff_a,
    input  logic signed [WORD_BITS-1:0] i_coeff_b,
    input  logic signed [WORD_BITS-1:0] i_coeff_c,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [qes_pkg::TOL_W-1:0]   i_cfg_data,
    output logic                        o_valid,
    output logic [1:0]                  o_root_count,
    output logic signed [WORD_BITS-1:0] o_first_root,
    output logic signed [WORD_BITS-1:0] o_second_root,
    output logic                        o_range_overflow
);
    import qes_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int DW   = 2 * W + 2;
    localparam int SQW  = W + 1;
    localparam int NS   = W + 2;
    localparam int NMW  = W + 1;
    localparam int NW   = NMW + F;
    localparam int DENW = W + 1;
    localparam int TW   = (W > TOL_W) ? W : TOL_W;
    localparam int CW   = (DW > TOL_W + F) ? DW : TOL_W + F;

    logic [TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // stage 1
    logic             r1_vld;
    logic [W-1:0]     r1_a, r1_b, r1_c;
    logic [TOL_W-1:0] r1_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a   <= i_coeff_a;
        r1_b   <= i_coeff_b;
        r1_c   <= i_coeff_c;
        r1_tol <= r_tol;
    end

    // stage 2: sign, magnitude, near-zero flags
    logic [TOL_W-1:0] thr;
    logic [W-1:0]     ma, mb, mc;

    always_comb begin
        thr = (r1_tol == '0) ? TOL_W'(1) : r1_tol;
        ma  = r1_a[W-1] ? -r1_a : r1_a;
        mb  = r1_b[W-1] ? -r1_b : r1_b;
        mc  = r1_c[W-1] ? -r1_c : r1_c;
    end

    logic             r2_vld;
    logic [W-1:0]     r2_ma, r2_mb, r2_mc;
    logic             r2_na, r2_nb, r2_nc;
    logic             r2_sa, r2_sb, r2_sc;
    logic [TOL_W-1:0] r2_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ma  <= ma;
        r2_mb  <= mb;
        r2_mc  <= mc;
        r2_na  <= r1_a[W-1];
        r2_nb  <= r1_b[W-1];
        r2_nc  <= r1_c[W-1];
        r2_sa  <= TW'(ma) < TW'(thr);
        r2_sb  <= TW'(mb) < TW'(thr);
        r2_sc  <= TW'(mc) < TW'(thr);
        r2_thr <= thr;
    end

    // stage 3: products
    logic             r3_vld;
    logic [PW-1:0]    r3_b2, r3_ac;
    logic [W-1:0]     r3_ma, r3_mb, r3_mc;
    logic             r3_na, r3_nb, r3_nc;
    logic             r3_sa, r3_sb, r3_sc;
    logic [TOL_W-1:0] r3_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_b2  <= PW'(r2_mb) * PW'(r2_mb);
        r3_ac  <= PW'(r2_ma) * PW'(r2_mc);
        r3_ma  <= r2_ma;
        r3_mb  <= r2_mb;
        r3_mc  <= r2_mc;
        r3_na  <= r2_na;
        r3_nb  <= r2_nb;
        r3_nc  <= r2_nc;
        r3_sa  <= r2_sa;
        r3_sb  <= r2_sb;
        r3_sc  <= r2_sc;
        r3_thr <= r2_thr;
    end

    // stage 4: discriminant and case selection
    logic [DW-1:0]   b2e, ac4, d;
    logic            d_neg, d_small;
    t_count          kind;
    logic [W:0]      nbase;
    logic [DENW-1:0] den;
    logic            den_neg;

    always_comb begin
        b2e   = DW'(r3_b2);
        ac4   = {r3_ac, 2'b00};
        d_neg = 1'b0;
        if (r3_na != r3_nc) begin
            d = b2e + ac4;
        end else if (b2e >= ac4) begin
            d = b2e - ac4;
        end else begin
            d     = ac4 - b2e;
            d_neg = 1'b1;
        end
        d_small = CW'(d) < (CW'(r3_thr) << F);

        nbase   = r3_nb ? {1'b0, r3_mb} : -{1'b0, r3_mb};
        den     = {r3_ma, 1'b0};
        den_neg = r3_na;
        if (r3_sa) begin
            if (r3_sb) begin
                kind = r3_sc ? CNT_INF : CNT_NONE;
            end else begin
                kind    = CNT_ONE;
                nbase   = r3_nc ? {1'b0, r3_mc} : -{1'b0, r3_mc};
                den     = {1'b0, r3_mb};
                den_neg = r3_nb;
            end
        end else if (d_small) begin
            kind = CNT_ONE;
        end else if (d_neg) begin
            kind = CNT_NONE;
        end else begin
            kind = CNT_TWO;
        end
    end

    t_ctl            r4_ctl;
    logic [DW-1:0]   r4_d;
    logic [W:0]      r4_nb;
    logic [DENW-1:0] r4_den;
    logic            r4_dneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl.vld <= 1'b0;
        end else begin
            r4_ctl.vld <= r3_vld;
        end
        r4_ctl.kind <= kind;
    end

    always_ff @(posedge i_clk) begin
        r4_d    <= d;
        r4_nb   <= nbase;
        r4_den  <= den;
        r4_dneg <= den_neg;
    end

    // square root, side data delayed alongside
    logic [SQW-1:0] sq_root;

    qes_sqrt #(.SQW(SQW)) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r4_d),
        .o_root (sq_root)
    );

    t_ctl            r_q_ctl  [SQW];
    logic [W:0]      r_q_nb   [SQW];
    logic [DENW-1:0] r_q_den  [SQW];
    logic            r_q_dneg [SQW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQW; i++) begin
                r_q_ctl[i].vld <= 1'b0;
            end
        end else begin
            r_q_ctl[0].vld <= r4_ctl.vld;
            for (int i = 1; i < SQW; i++) begin
                r_q_ctl[i].vld <= r_q_ctl[i-1].vld;
            end
        end
        r_q_ctl[0].kind <= r4_ctl.kind;
        for (int i = 1; i < SQW; i++) begin
            r_q_ctl[i].kind <= r_q_ctl[i-1].kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_nb[0]   <= r4_nb;
        r_q_den[0]  <= r4_den;
        r_q_dneg[0] <= r4_dneg;
        for (int i = 1; i < SQW; i++) begin
            r_q_nb[i]   <= r_q_nb[i-1];
            r_q_den[i]  <= r_q_den[i-1];
            r_q_dneg[i] <= r_q_dneg[i-1];
        end
    end

    // stage 5: numerators
    t_ctl           q_ctl;
    logic [NS-1:0]  nbx, sx, n1, n2;
    logic [NMW-1:0] m1, m2;

    always_comb begin
        q_ctl = r_q_ctl[SQW-1];
        nbx   = {r_q_nb[SQW-1][W], r_q_nb[SQW-1]};
        sx    = NS'(sq_root);
        if (q_ctl.kind == CNT_TWO) begin
            n1 = nbx + sx;
            n2 = nbx - sx;
        end else begin
            n1 = nbx;
            n2 = '0;
        end
        m1 = n1[NS-1] ? NMW'(-n1) : NMW'(n1);
        m2 = n2[NS-1] ? NMW'(-n2) : NMW'(n2);
    end

    t_ctl            r5_ctl;
    logic [NMW-1:0]  r5_m1, r5_m2;
    logic            r5_s1, r5_s2;
    logic [DENW-1:0] r5_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl.vld <= 1'b0;
        end else begin
            r5_ctl.vld <= q_ctl.vld;
        end
        r5_ctl.kind <= q_ctl.kind;
    end

    always_ff @(posedge i_clk) begin
        r5_m1  <= m1;
        r5_m2  <= m2;
        r5_s1  <= n1[NS-1] ^ r_q_dneg[SQW-1];
        r5_s2  <= n2[NS-1] ^ r_q_dneg[SQW-1];
        r5_den <= r_q_den[SQW-1];
    end

    // dividers
    logic [W-1:0] root1, root2;
    logic         ovf1, ovf2;

    qes_div #(.NW(NW), .DENW(DENW), .WB(W)) u_div1 (
        .i_clk  (i_clk),
        .i_mag  ({r5_m1, F'(0)}),
        .i_neg  (r5_s1),
        .i_den  (r5_den),
        .o_root (root1),
        .o_ovf  (ovf1)
    );

    qes_div #(.NW(NW), .DENW(DENW), .WB(W)) u_div2 (
        .i_clk  (i_clk),
        .i_mag  ({r5_m2, F'(0)}),
        .i_neg  (r5_s2),
        .i_den  (r5_den),
        .o_root (root2),
        .o_ovf  (ovf2)
    );

    t_ctl r_d_ctl [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NW; i++) begin
                r_d_ctl[i].vld <= 1'b0;
            end
        end else begin
            r_d_ctl[0].vld <= r5_ctl.vld;
            for (int i = 1; i <= NW; i++) begin
                r_d_ctl[i].vld <= r_d_ctl[i-1].vld;
            end
        end
        r_d_ctl[0].kind <= r5_ctl.kind;
        for (int i = 1; i <= NW; i++) begin
            r_d_ctl[i].kind <= r_d_ctl[i-1].kind;
        end
    end

    // output register
    t_ctl         f_ctl;
    logic [W-1:0] n_first, n_second;
    logic         n_ovf;

    always_comb begin
        f_ctl    = r_d_ctl[NW];
        n_first  = '0;
        n_second = '0;
        n_ovf    = 1'b0;
        case (f_ctl.kind)
            CNT_ONE: begin
                n_first = root1;
                n_ovf   = ovf1;
            end
            CNT_TWO: begin
                n_first  = root1;
                n_second = root2;
                n_ovf    = ovf1 | ovf2;
            end
            default: begin
                n_ovf = 1'b0;
            end
        endcase
    end

    logic         r_valid;
    t_count       r_count;
    logic [W-1:0] r_first, r_second;
    logic         r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= f_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= f_ctl.kind;
        r_first  <= n_first;
        r_second <= n_second;
        r_ovf    <= n_ovf;
    end

    assign o_valid          = r_valid;
    assign o_root_count     = r_count;
    assign o_first_root     = r_first;
    assign o_second_root    = r_second;
    assign o_range_overflow = r_ovf;

endmodule

/* hdl/qes_checker.sv */
`timescale 1ns / 1ps
module qes_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 busy,
    input logic                 o_cfg_ready,
    input logic                 o_valid,
    input logic [1:0]           o_root_count,
    input logic [WORD_BITS-1:0] o_first_root,
    input logic [WORD_BITS-1:0] o_second_root,
    input logic                 o_range_overflow
);
    import qes_pkg::*;

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("block refused a transaction");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == CNT_NONE || o_root_count == CNT_INF)
        |-> o_first_root == '0 && o_second_root == '0 && !o_range_overflow)
        else $error("root fields set without a root");

    a_one_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count == CNT_ONE |-> o_second_root == '0)
        else $error("second root set for a single root");

endmodule

bind quadratic_equation_solver_unit qes_checker #(.WORD_BITS(WORD_BITS)) u_qes_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_cfg_ready      (o_cfg_ready),
    .o_valid          (o_valid),
    .o_root_count     (o_root_count),
    .o_first_root     (o_first_root),
    .o_second_root    (o_second_root),
    .o_range_overflow (o_range_overflow)
);
